>>> design/ntcba_pkg.sv
// Package for the NTC thermistor temperature averager.
// Holds window size, fixed-point constants, register indexes and the sequencer state type.
// No dependencies.
package ntcba_pkg;

	localparam int WINDOW_DEPTH = 100;
	localparam int SLOT_W       = $clog2(WINDOW_DEPTH);
	localparam int CNT_W        = $clog2(WINDOW_DEPTH + 1);

	localparam logic [29:0] LN2_Q30        = 30'd744261118;
	localparam logic [22:0] SCALE_Q16_C    = 23'd6553600;
	localparam logic signed [17:0] KELVIN_OFFSET = 18'sd27315;
	localparam logic signed [17:0] OUT_HIGH      = 18'sd32767;

	localparam logic [2:0] CFG_FULL_SCALE = 3'd0;
	localparam logic [2:0] CFG_SERIES     = 3'd1;
	localparam logic [2:0] CFG_NOMINAL    = 3'd2;
	localparam logic [2:0] CFG_BETA       = 3'd3;
	localparam logic [2:0] CFG_REF_TEMP   = 3'd4;

	typedef enum logic [3:0] {
		S_IDLE,
		S_MUL_P,
		S_MUL_Q,
		S_NORM,
		S_SQ,
		S_LN,
		S_DEN_A,
		S_DEN_B,
		S_NUM_A,
		S_NUM_B,
		S_DIV_SET,
		S_DIV,
		S_TEMP,
		S_UPDATE,
		S_MEAN_SET,
		S_DONE
	} state_t;

endpackage

>>> design/ntcba_if.sv
// Handshake channels of the NTC thermistor temperature averager.
// Depends on nothing; one interface for samples, one for results.
interface ntcba_sample_if;
	logic        valid;
	logic        ready;
	logic [15:0] adc_sample;
	modport source (output valid, output adc_sample, input ready);
	modport sink (input valid, input adc_sample, output ready);
endinterface

interface ntcba_result_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] average_centi_c;
	logic signed [15:0] sample_centi_c;
	logic [6:0]         held_count;
	logic               sample_fault;
	logic               saturated;
	modport source (output valid, output average_centi_c, output sample_centi_c,
		output held_count, output sample_fault, output saturated, input ready);
	modport sink (input valid, input average_centi_c, input sample_centi_c,
		input held_count, input sample_fault, input saturated, output ready);
endinterface

>>> design/ntc_beta_temperature_averager.sv
// NTC thermistor temperature averager: beta equation with fixed-point log, 100-entry mean.
// Per item: two logs, then a 17-step divide for the temperature and a 16-step divide for
// the mean; a temperature that clips before the divide skips it, a faulted item also skips
// the logs, and a faulted item with the window empty skips both divides. One item at a time:
// ready again in the cycle the result turns valid, later while the result waits for ready.
// Reset: configuration to defaults, window empty; the ring itself is not cleared.
module ntc_beta_temperature_averager (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [19:0] cfg_data,
	ntcba_sample_if.sink   sample,
	ntcba_result_if.source result
);
	import ntcba_pkg::*;

	state_t state_q, state_d;

	logic [15:0] fs_q;
	logic [19:0] series_q, nominal_q;
	logic [13:0] beta_q;
	logic [15:0] t0_q;

	logic [15:0] x_q;
	logic [35:0] v_q;
	logic [5:0]  sh_q;
	logic [4:0]  cnt_q;
	logic        which_q;
	logic [30:0] m_q;
	logic [15:0] frac_q;
	logic [21:0] l2p_q;
	logic signed [22:0] l2_q;
	logic signed [23:0] ln_q;
	logic signed [39:0] den_q;
	logic [29:0] tmp_q;
	logic [53:0] num_q;
	logic [54:0] rem_q, dv_q;
	logic [16:0] quo_q;
	logic        mean_q;
	logic signed [15:0] temp_q;
	logic        sat_q, fault_q;

	logic [SLOT_W-1:0] slot_q;
	logic [CNT_W-1:0]  count_q;
	logic signed [22:0] sum_q;
	logic signed [15:0] ring_mem [WINDOW_DEPTH];
	logic signed [15:0] old_q;

	logic        ovalid_q;
	logic signed [15:0] oavg_q, otemp_q;
	logic [6:0]  ocount_q;
	logic        ofault_q, osat_q;

	logic signed [32:0] mul_a, mul_b;
	logic signed [65:0] prod;

	ntcba_mul u_mul (.a(mul_a), .b(mul_b), .p(prod));

	// combinational helpers
	logic        in_fault;
	logic [5:0]  amt;
	logic [35:0] topmask, v_n;
	logic [5:0]  sh_n;
	logic [31:0] sq;
	logic [30:0] m_n;
	logic [15:0] frac_n;
	logic [21:0] logv;
	logic [21:0] l2mag;
	logic [52:0] lnsum;
	logic [22:0] lnm;
	logic        den_pos, div_ovf;
	logic [54:0] n_temp;
	logic        div_ge, div_last;
	logic signed [17:0] c_temp;
	logic [21:0] sum_mag;
	logic        out_free;

	assign in_fault = (sample.adc_sample == 16'd0) || (sample.adc_sample >= fs_q)
		|| (series_q == 20'd0) || (nominal_q == 20'd0);
	assign amt     = 6'd32 >> cnt_q[2:0];
	assign topmask = ~({36{1'b1}} >> amt);
	assign v_n     = ((v_q & topmask) == 36'd0) ? (v_q << amt) : v_q;
	assign sh_n    = ((v_q & topmask) == 36'd0) ? (sh_q + amt) : sh_q;
	assign sq      = prod[61:30];
	assign m_n     = sq[31] ? sq[31:1] : sq[30:0];
	assign frac_n  = {frac_q[14:0], sq[31]};
	assign logv    = {6'd35 - sh_q, frac_n};
	assign l2mag   = l2_q[22] ? 22'(-l2_q) : 22'(l2_q);
	assign lnsum   = prod[52:0] + 53'(1 << 29);
	assign lnm     = lnsum[52:30];
	assign den_pos = den_q > 40'sd0;
	assign n_temp  = 55'(num_q) + 55'(den_q[39:1]);
	assign div_ovf = n_temp >= (55'(den_q) << 17);
	assign div_ge  = rem_q >= dv_q;
	assign div_last = mean_q ? (cnt_q == 5'd15) : (cnt_q == 5'd16);
	assign c_temp  = signed'({1'b0, quo_q}) - KELVIN_OFFSET;
	assign sum_mag = sum_q[22] ? 22'(-sum_q) : 22'(sum_q);
	assign out_free = !ovalid_q || result.ready;

	// multiplier operand selection
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_MUL_P: begin
				mul_a = 33'(series_q);
				mul_b = 33'(fs_q - x_q);
			end
			S_MUL_Q: begin
				mul_a = 33'(x_q);
				mul_b = 33'(nominal_q);
			end
			S_SQ: begin
				mul_a = 33'(m_q);
				mul_b = 33'(m_q);
			end
			S_LN: begin
				mul_a = 33'(l2mag);
				mul_b = 33'(LN2_Q30);
			end
			S_DEN_A: begin
				mul_a = 33'(beta_q);
				mul_b = 33'(SCALE_Q16_C);
			end
			S_DEN_B: begin
				mul_a = 33'(t0_q);
				mul_b = 33'(ln_q);
			end
			S_NUM_A: begin
				mul_a = 33'(beta_q);
				mul_b = 33'(t0_q);
			end
			S_NUM_B: begin
				mul_a = 33'(tmp_q);
				mul_b = 33'(SCALE_Q16_C);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE:     if (sample.valid) state_d = in_fault ? S_MEAN_SET : S_MUL_P;
			S_MUL_P:    state_d = S_NORM;
			S_MUL_Q:    state_d = S_NORM;
			S_NORM:     if (cnt_q == 5'd5) state_d = S_SQ;
			S_SQ:       if (cnt_q == 5'd15) state_d = which_q ? S_LN : S_MUL_Q;
			S_LN:       state_d = S_DEN_A;
			S_DEN_A:    state_d = S_DEN_B;
			S_DEN_B:    state_d = S_NUM_A;
			S_NUM_A:    state_d = S_NUM_B;
			S_NUM_B:    state_d = S_DIV_SET;
			S_DIV_SET:  state_d = (!den_pos || div_ovf) ? S_UPDATE : S_DIV;
			S_DIV:      if (div_last) state_d = mean_q ? S_DONE : S_TEMP;
			S_TEMP:     state_d = S_UPDATE;
			S_UPDATE:   state_d = S_MEAN_SET;
			S_MEAN_SET: state_d = (count_q == '0) ? S_DONE : S_DIV;
			S_DONE:     if (out_free) state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	assign sample.ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			fs_q      <= 16'd4095;
			series_q  <= 20'd10000;
			nominal_q <= 20'd10000;
			beta_q    <= 14'd3950;
			t0_q      <= 16'd29815;
			slot_q    <= '0;
			count_q   <= '0;
			sum_q     <= '0;
			ovalid_q  <= 1'b0;
			cnt_q     <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					CFG_FULL_SCALE: fs_q      <= cfg_data[15:0];
					CFG_SERIES:     series_q  <= cfg_data;
					CFG_NOMINAL:    nominal_q <= cfg_data;
					CFG_BETA:       beta_q    <= cfg_data[13:0];
					CFG_REF_TEMP:   t0_q      <= cfg_data[15:0];
					default: ;
				endcase
			end
			if (state_q == S_DONE && out_free) ovalid_q <= 1'b1;
			else if (result.ready) ovalid_q <= 1'b0;
			case (state_q)
				S_NORM:   cnt_q <= (cnt_q == 5'd5) ? 5'd0 : cnt_q + 5'd1;
				S_SQ:     cnt_q <= (cnt_q == 5'd15) ? 5'd0 : cnt_q + 5'd1;
				S_DIV:    cnt_q <= div_last ? 5'd0 : cnt_q + 5'd1;
				default:  cnt_q <= 5'd0;
			endcase
			if (state_q == S_UPDATE) begin
				if (count_q >= CNT_W'(WINDOW_DEPTH)) begin
					sum_q <= sum_q + 23'(temp_q) - 23'(old_q);
				end else begin
					count_q <= count_q + 1'b1;
					sum_q   <= sum_q + 23'(temp_q);
				end
				slot_q <= (slot_q == SLOT_W'(WINDOW_DEPTH - 1)) ? '0 : slot_q + 1'b1;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				x_q     <= sample.adc_sample;
				fault_q <= in_fault;
				temp_q  <= '0;
				sat_q   <= 1'b0;
				which_q <= 1'b0;
			end
			S_MUL_P, S_MUL_Q: begin
				v_q  <= prod[35:0];
				sh_q <= '0;
			end
			S_NORM: begin
				v_q  <= v_n;
				sh_q <= sh_n;
				if (cnt_q == 5'd5) begin
					m_q    <= v_n[35:5];
					frac_q <= '0;
				end
			end
			S_SQ: begin
				m_q    <= m_n;
				frac_q <= frac_n;
				if (cnt_q == 5'd15) begin
					if (!which_q) l2p_q <= logv;
					else l2_q <= signed'({1'b0, l2p_q}) - signed'({1'b0, logv});
					which_q <= 1'b1;
				end
			end
			S_LN:    ln_q <= l2_q[22] ? -signed'({1'b0, lnm}) : signed'({1'b0, lnm});
			S_DEN_A: den_q <= prod[39:0];
			S_DEN_B: den_q <= den_q + prod[39:0];
			S_NUM_A: tmp_q <= prod[29:0];
			S_NUM_B: num_q <= prod[53:0];
			S_DIV_SET: begin
				if (!den_pos || div_ovf) begin
					temp_q <= 16'(OUT_HIGH);
					sat_q  <= 1'b1;
				end
				rem_q  <= n_temp;
				dv_q   <= 55'(den_q) << 16;
				quo_q  <= '0;
				mean_q <= 1'b0;
			end
			S_DIV: begin
				if (div_ge) rem_q <= rem_q - dv_q;
				quo_q <= {quo_q[15:0], div_ge};
				dv_q  <= dv_q >> 1;
			end
			S_TEMP: begin
				if (c_temp > OUT_HIGH) begin
					temp_q <= 16'(OUT_HIGH);
					sat_q  <= 1'b1;
				end else begin
					temp_q <= 16'(c_temp);
				end
			end
			S_MEAN_SET: begin
				rem_q  <= 55'(sum_mag) + 55'(count_q >> 1);
				dv_q   <= 55'(count_q) << 15;
				quo_q  <= '0;
				mean_q <= 1'b1;
			end
			S_DONE: begin
				if (out_free) begin
					if (count_q == '0) oavg_q <= '0;
					else oavg_q <= sum_q[22] ? -signed'(quo_q[15:0]) : signed'(quo_q[15:0]);
					otemp_q  <= temp_q;
					ocount_q <= 7'(count_q);
					ofault_q <= fault_q;
					osat_q   <= sat_q;
				end
			end
			default: ;
		endcase
	end

	// temperature ring, registered read at the slot about to be overwritten
	always_ff @(posedge clk) begin
		if (state_q == S_UPDATE) ring_mem[slot_q] <= temp_q;
		old_q <= ring_mem[slot_q];
	end

	assign result.valid           = ovalid_q;
	assign result.average_centi_c = oavg_q;
	assign result.sample_centi_c  = otemp_q;
	assign result.held_count      = ocount_q;
	assign result.sample_fault    = ofault_q;
	assign result.saturated       = osat_q;

endmodule

>>> design/ntcba_mul.sv
// Shared signed 33x33 multiplier of the averager datapath.
// Combinational; the caller registers the product. No dependencies.
module ntcba_mul (
	input  logic signed [32:0] a,
	input  logic signed [32:0] b,
	output logic signed [65:0] p
);
	assign p = a * b;
endmodule

>>> tb/ntcba_tb_if.sv
// Testbench-side notes: the channel interfaces come from the design folder (ntcba_if.sv).
// This file holds the shared testbench constants; it depends on no other file.
`timescale 1ns / 1ps
package ntcba_tb_pkg;
	localparam int IDLE_MAX     = 13;
	localparam int WATCHDOG_MAX = 20000;
	localparam int SAT_LOW      = -27315;
	localparam int SAT_HIGH     = 32767;
endpackage

>>> tb/ntcba_checker.sv
// Checker for the NTC temperature averager: mirrors configuration writes, predicts each
// result from accepted samples and compares it with the result channel.
// Depends on ntcba_pkg and ntcba_tb_pkg.
`timescale 1ns / 1ps
module ntcba_checker
	import ntcba_pkg::*;
	import ntcba_tb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [19:0] cfg_data,
	input  logic        s_valid,
	input  logic        s_ready,
	input  logic [15:0] s_adc,
	input  logic        r_valid,
	input  logic        r_ready,
	input  logic signed [15:0] r_avg,
	input  logic signed [15:0] r_temp,
	input  logic [6:0]  r_held,
	input  logic        r_fault,
	input  logic        r_sat,
	output int          mismatches,
	output int          pending
);
	typedef struct packed {
		logic signed [15:0] avg;
		logic signed [15:0] temp;
		logic [6:0]         held;
		logic               fault;
		logic               sat;
	} reading_t;

	reading_t readings_due[$];

	logic [15:0] full_scale;
	logic [19:0] series_r, nominal_r;
	logic [13:0] beta;
	logic [15:0] t0_ck;
	int window[WINDOW_DEPTH];
	int slot, held, sum;

	function automatic longint log2_fix(longint unsigned v);
		int k;
		longint unsigned m, frac;
		if (v == 0) return 0;
		k = 63;
		while (((v >> k) & 1) == 0) k--;
		m = (k <= 30) ? (v << (30 - k)) : (v >> (k - 30));
		frac = 0;
		for (int i = 0; i < 16; i++) begin
			m = (m * m) >> 30;
			frac = frac << 1;
			if (m >= (64'd2 << 30)) begin
				m = m >> 1;
				frac = frac | 1;
			end
		end
		return longint'(k) * 65536 + longint'(frac);
	endfunction

	function automatic int held_mean();
		int mag, q;
		if (held == 0) return 0;
		mag = (sum < 0) ? -sum : sum;
		q = (mag + held / 2) / held;
		return (sum < 0) ? -q : q;
	endfunction

	task automatic predict_reading(input logic [15:0] x);
		reading_t rd;
		longint l2, mag, lnv, den, num, c;
		rd = '0;
		if (x == 0 || x >= full_scale || series_r == 0 || nominal_r == 0) begin
			rd.fault = 1'b1;
		end else begin
			l2 = log2_fix(longint'(series_r) * longint'(full_scale - x))
				- log2_fix(longint'(x) * longint'(nominal_r));
			mag = (l2 < 0) ? -l2 : l2;
			lnv = (mag * 744261118 + (64'sd1 <<< 29)) >>> 30;
			if (l2 < 0) lnv = -lnv;
			den = longint'(beta) * 6553600 + longint'(t0_ck) * lnv;
			if (den <= 0) c = SAT_HIGH + 1;
			else begin
				num = longint'(beta) * longint'(t0_ck) * 6553600;
				c = (num + den / 2) / den - 27315;
			end
			if (c > SAT_HIGH) begin c = SAT_HIGH; rd.sat = 1'b1; end
			else if (c < SAT_LOW) begin c = SAT_LOW; rd.sat = 1'b1; end
			rd.temp = 16'(c);
			if (held >= WINDOW_DEPTH) sum -= window[slot];
			else held++;
			window[slot] = int'(c);
			sum += int'(c);
			slot = (slot + 1) % WINDOW_DEPTH;
		end
		rd.avg = 16'(held_mean());
		rd.held = 7'(held);
		readings_due.push_back(rd);
	endtask

	assign pending = readings_due.size();

	always @(posedge clk or negedge arst_n) begin
		reading_t want;
		if (!arst_n) begin
			full_scale = 4095; series_r = 10000; nominal_r = 10000;
			beta = 3950; t0_ck = 29815;
			slot = 0; held = 0; sum = 0;
			mismatches = 0;
			readings_due.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_FULL_SCALE: full_scale = cfg_data[15:0];
					CFG_SERIES:     series_r = cfg_data;
					CFG_NOMINAL:    nominal_r = cfg_data;
					CFG_BETA:       beta = cfg_data[13:0];
					CFG_REF_TEMP:   t0_ck = cfg_data[15:0];
					default: ;
				endcase
			end
			if (r_valid && r_ready) begin
				if (readings_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("unexpected result item");
				end else begin
					want = readings_due.pop_front();
					if (want != {r_avg, r_temp, r_held, r_fault, r_sat}) begin
						mismatches++;
						if (mismatches <= 10)
							$display("result: exp avg %0d temp %0d held %0d f %b s %b, got avg %0d temp %0d held %0d f %b s %b",
								want.avg, want.temp, want.held, want.fault, want.sat,
								r_avg, r_temp, r_held, r_fault, r_sat);
					end
				end
			end
			if (s_valid && s_ready) predict_reading(s_adc);
		end
	end
endmodule

>>> tb/tb_top.sv
// Top of the NTC temperature averager testbench: clock, reset, configuration phases,
// sample stimulus with random idling and a long output hold-off, and the verdict.
// Depends on ntcba_pkg, ntcba_tb_pkg, the channel interfaces and ntcba_checker.
`timescale 1ns / 1ps
module tb_top;
	import ntcba_pkg::*;
	import ntcba_tb_pkg::*;

	logic clk, arst_n, cfg_we;
	logic [2:0] cfg_index;
	logic [19:0] cfg_data;
	int mismatches, pending, quiet;
	bit calm, hold_long;
	logic [15:0] fs_now;

	ntcba_sample_if sample();
	ntcba_result_if result();

	ntc_beta_temperature_averager DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .sample(sample.sink), .result(result.source)
	);

	ntcba_checker u_checker (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .s_valid(sample.valid), .s_ready(sample.ready),
		.s_adc(sample.adc_sample), .r_valid(result.valid), .r_ready(result.ready),
		.r_avg(result.average_centi_c), .r_temp(result.sample_centi_c),
		.r_held(result.held_count), .r_fault(result.sample_fault),
		.r_sat(result.saturated), .mismatches(mismatches), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		sample.valid = 1'b0; sample.adc_sample = '0; result.ready = 1'b0;
		cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
	end

	// watchdog on cycles with no accepted item
	always @(posedge clk) begin
		if ((sample.valid && sample.ready) || (result.valid && result.ready)) quiet <= 0;
		else quiet <= quiet + 1;
		if (quiet > WATCHDOG_MAX) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// result side: random stalls, one long hold-off
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_long) begin
				result.ready <= 1'b0;
				repeat (400) @(posedge clk);
				hold_long = 0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, IDLE_MAX);
				result.ready <= 1'b0;
				repeat (n - 1) @(posedge clk);
			end else result.ready <= 1'b1;
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [19:0] val);
		@(posedge clk);
		cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
		if (idx == CFG_FULL_SCALE) fs_now = val[15:0];
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// valid stays up after the accepting edge; the next call or settle() drives it
	task automatic send_sample(input logic [15:0] x);
		if (!calm && $urandom_range(0, 4) == 0) begin
			sample.valid <= 1'b0;
			repeat ($urandom_range(1, IDLE_MAX)) @(posedge clk);
		end
		sample.valid <= 1'b1;
		sample.adc_sample <= x;
		do @(posedge clk); while (!sample.ready);
	endtask

	task automatic settle();
		sample.valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (150) @(posedge clk);
	endtask

	function automatic logic [15:0] pick_sample();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0) return 16'($urandom());
		if (r == 1) return ($urandom_range(0, 1) == 0) ? 16'd0 : fs_now;
		if (fs_now <= 2) return 16'd1;
		return 16'($urandom_range(1, fs_now - 1));
	endfunction

	initial begin
		@(posedge arst_n);
		fs_now = 4095;
		// directed: extremes, faults, defaults
		send_sample(16'd0); send_sample(16'd1); send_sample(16'd2047);
		send_sample(16'd4094); send_sample(16'd4095); send_sample(16'hFFFF);
		send_sample(16'd100); send_sample(16'd3900);
		settle();
		// hot extreme: nonpositive denominator, and cold clip
		write_reg(CFG_FULL_SCALE, 20'd65535); write_reg(CFG_SERIES, 20'd1);
		write_reg(CFG_NOMINAL, 20'd1000000); write_reg(CFG_BETA, 20'd1000);
		write_reg(CFG_REF_TEMP, 20'd40000);
		send_sample(16'd65534); send_sample(16'd1); send_sample(16'd32768);
		send_sample(16'hAAAA); send_sample(16'h5555);
		settle();
		write_reg(CFG_SERIES, 20'd1000000); write_reg(CFG_NOMINAL, 20'd1);
		write_reg(CFG_BETA, 20'd10000); write_reg(CFG_REF_TEMP, 20'd20000);
		send_sample(16'd1); send_sample(16'd65534); send_sample(16'd30000);
		settle();
		write_reg(CFG_FULL_SCALE, 20'd1); send_sample(16'd0); send_sample(16'd1);
		settle();
		write_reg(CFG_FULL_SCALE, 20'd2); send_sample(16'd1);
		settle();
		// pressure: output held off while samples keep coming
		write_reg(CFG_FULL_SCALE, 20'd4095); write_reg(CFG_SERIES, 20'd10000);
		write_reg(CFG_NOMINAL, 20'd10000); write_reg(CFG_BETA, 20'd3950);
		write_reg(CFG_REF_TEMP, 20'd29815);
		hold_long = 1;
		repeat (8) send_sample(pick_sample());
		settle();
		for (int ph = 0; ph < 7; ph++) begin
			write_reg(CFG_FULL_SCALE, 20'($urandom_range(2, 65535)));
			write_reg(CFG_SERIES, 20'($urandom_range(1, 1000000)));
			write_reg(CFG_NOMINAL, 20'($urandom_range(1, 1000000)));
			write_reg(CFG_BETA, 20'($urandom_range(1000, 10000)));
			write_reg(CFG_REF_TEMP, 20'($urandom_range(20000, 40000)));
			if (ph == 6) calm = 1;
			repeat (205) send_sample(pick_sample());
			settle();
		end
		if (mismatches == 0) $display("No mismatches found");
		else $display("Mismatches found");
		$finish;
	end
endmodule
